// ----- hdl/spims_pkg.sv -----
// ----------------------------------------------------------------------------
// spims_pkg
// Shared types and constants for the SPI master mode shifter: command
// codes, the classified command record and the configuration record.
// ----------------------------------------------------------------------------
package spims_pkg;

   // Widths of the stream payloads and the configuration port
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Command kinds on the request channel
   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_SELECT   = 2'd1,
      OP_DESELECT = 2'd2,
      OP_TICK     = 2'd3
   } op_type;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_SPI_MODE   = 2'd0,
      REG_HALF_DELAY = 2'd1,
      REG_CS_ENABLED = 2'd2,
      REG_CS_POL_LOW = 2'd3
   } reg_type;

   // Classified command as it travels through the queue
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       miso_level;
   } cmd_type;

   // Current configuration
   typedef struct packed {
      logic [1:0]  spi_mode;
      logic [15:0] half_delay;
      logic        cs_enabled;
      logic        cs_pol_low;
   } cfg_type;

   // Configuration update strobes seen by the shifter
   typedef struct packed {
      logic mode_wr;
      logic cs_wr;
   } cfg_evt_type;

endpackage

// ----- hdl/spims_front.sv -----
// ----------------------------------------------------------------------------
// spims_front
// Request side: accepts items, classifies the kind into a command and
// holds it in one register stage until the queue takes it.
// ----------------------------------------------------------------------------
module spims_front
   import spims_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] tx_byte, [8] miso_level
   input  logic [1:0]            req_tuser,   // [1:0] kind
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   // stage is free when empty or being drained
   assign req_tready = !valid_ff || cmd_ready;

   // classify the incoming item
   always_comb begin
      cmd_in = cmd_ff;
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         if (req_tvalid) begin
            cmd_in.op         = op_type'(req_tuser);
            cmd_in.tx_byte    = req_tdata[7:0];
            cmd_in.miso_level = req_tdata[8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ----- hdl/spims_queue.sv -----
// ----------------------------------------------------------------------------
// spims_queue
// Two-entry command queue between the request stage and the shifter.
// ----------------------------------------------------------------------------
module spims_queue
   import spims_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/spims_back.sv -----
// ----------------------------------------------------------------------------
// spims_back
// Shifter: executes queued commands against the bit and phase state,
// drives the pin levels and registers one result per command.
// ----------------------------------------------------------------------------
module spims_back
   import spims_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cfg_evt_type           cfg_evt,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] sck_level, [1] mosi_level, [2] cs_level, [10:3] rx_byte,
   // [11] byte_done, [12] busy_res, [13] rejected, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_TRAIL = 2'd1,
      PH_TAIL  = 2'd2
   } phase_type;

   logic [7:0]            tx_shift_ff, tx_shift_in;
   logic [7:0]            rx_shift_ff, rx_shift_in;
   logic [2:0]            bit_index_ff, bit_index_in;
   phase_type             bit_phase_ff, bit_phase_in;
   logic [15:0]           phase_ticks_ff, phase_ticks_in;
   logic                  active_ff, active_in;
   logic                  sck_ff, sck_in;
   logic                  mosi_ff, mosi_in;
   logic                  cs_ff, cs_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic        idle_lvl, cpha, deassert;
   logic [15:0] limit;
   logic        phase_end;
   logic        take;
   logic        done, rej;
   logic [7:0]  rx_out;
   logic [2:0]  next_index;

   assign idle_lvl  = cfg.spi_mode[1];
   assign cpha      = cfg.spi_mode[0];
   assign deassert  = cfg.cs_pol_low;
   assign limit     = (cfg.half_delay == 16'd0) ? 16'd1 : cfg.half_delay;
   assign phase_end = ({1'b0, phase_ticks_ff} + 17'd1) >= {1'b0, limit};
   assign next_index = bit_index_ff + 3'd1;

   // output register frees up when empty or taken
   assign cmd_ready = !out_valid_ff || rsp_tready;
   assign take      = cmd_valid && cmd_ready;

   // command execution
   always_comb begin
      tx_shift_in    = tx_shift_ff;
      rx_shift_in    = rx_shift_ff;
      bit_index_in   = bit_index_ff;
      bit_phase_in   = bit_phase_ff;
      phase_ticks_in = phase_ticks_ff;
      active_in      = active_ff;
      sck_in         = sck_ff;
      mosi_in        = mosi_ff;
      cs_in          = cs_ff;
      done           = 1'b0;
      rej            = 1'b0;
      rx_out         = 8'd0;

      if (cfg_evt.mode_wr) begin
         // mode change aborts and parks SCK and MOSI
         active_in      = 1'b0;
         bit_index_in   = 3'd0;
         bit_phase_in   = PH_LEAD;
         phase_ticks_in = 16'd0;
         sck_in         = idle_lvl;
         mosi_in        = 1'b0;
      end
      if (cfg_evt.cs_wr) begin
         cs_in = deassert;
      end

      if (take) begin
         if (cmd.op != OP_TICK && active_ff) begin
            rej = 1'b1;
         end else begin
            case (cmd.op)
               OP_START: begin
                  tx_shift_in    = cmd.tx_byte;
                  rx_shift_in    = 8'd0;
                  bit_index_in   = 3'd0;
                  active_in      = 1'b1;
                  bit_phase_in   = PH_LEAD;
                  phase_ticks_in = 16'd0;
                  mosi_in        = cmd.tx_byte[7];
                  if (cpha) begin
                     sck_in = !idle_lvl;
                  end
               end
               OP_SELECT: begin
                  if (cfg.cs_enabled) begin
                     cs_in = !deassert;
                  end
               end
               OP_DESELECT: begin
                  if (cfg.cs_enabled) begin
                     cs_in = deassert;
                  end
               end
               OP_TICK: begin
                  if (active_ff) begin
                     if (phase_end) begin
                        phase_ticks_in = 16'd0;
                        case (bit_phase_ff)
                           PH_LEAD: begin
                              sck_in       = cpha ? idle_lvl : !idle_lvl;
                              bit_phase_in = PH_TRAIL;
                           end
                           PH_TRAIL: begin
                              rx_shift_in = {rx_shift_ff[6:0], cmd.miso_level};
                              if (!cpha) begin
                                 sck_in = idle_lvl;
                              end
                              bit_phase_in = PH_TAIL;
                           end
                           default: begin
                              if (bit_index_ff == 3'd7) begin
                                 done         = 1'b1;
                                 rx_out       = rx_shift_ff;
                                 active_in    = 1'b0;
                                 bit_index_in = 3'd0;
                                 bit_phase_in = PH_LEAD;
                              end else begin
                                 // next bit begins
                                 bit_index_in = next_index;
                                 bit_phase_in = PH_LEAD;
                                 mosi_in      = tx_shift_ff[3'd7 - next_index];
                                 if (cpha) begin
                                    sck_in = !idle_lvl;
                                 end
                              end
                           end
                        endcase
                     end else begin
                        phase_ticks_in = phase_ticks_ff + 16'd1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // result register
      out_valid_in = take ? 1'b1 : (out_valid_ff && !rsp_tready);
      out_data_in  = take ? {2'b00, rej, active_in, done, rx_out, cs_in, mosi_in, sck_in}
                          : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff    <= 8'd0;
         rx_shift_ff    <= 8'd0;
         bit_index_ff   <= 3'd0;
         bit_phase_ff   <= PH_LEAD;
         phase_ticks_ff <= 16'd0;
         active_ff      <= 1'b0;
         sck_ff         <= 1'b0;
         mosi_ff        <= 1'b0;
         cs_ff          <= 1'b1;
         out_valid_ff   <= 1'b0;
      end else begin
         tx_shift_ff    <= tx_shift_in;
         rx_shift_ff    <= rx_shift_in;
         bit_index_ff   <= bit_index_in;
         bit_phase_ff   <= bit_phase_in;
         phase_ticks_ff <= phase_ticks_in;
         active_ff      <= active_in;
         sck_ff         <= sck_in;
         mosi_ff        <= mosi_in;
         cs_ff          <= cs_in;
         out_valid_ff   <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hdl/spi_master_mode_shifter.sv -----
// ----------------------------------------------------------------------------
// spi_master_mode_shifter
// SPI master (modes 0 to 3) driven by a stream of commands and time ticks.
// ----------------------------------------------------------------------------
// Each request item (start, select, deselect or tick) yields exactly one
// response item carrying the SCK, MOSI and CS pin levels after that item,
// plus the received byte and a done flag when the eighth bit completes.
// The block takes one item per clock while neither side stalls: a request
// register, a two-entry command queue and the shifter's output register lie
// between request and response, and either side may stall without holding
// up the other until the queue fills.
// Bit timing is counted in tick items, not clock cycles: every bit has three
// phases of max(1, half_delay) ticks. The user writes registers through the
// APB-style port only while no item is in flight; the block does not enforce
// it. Writing spi_mode aborts a transfer and parks SCK at the new idle level.
// ----------------------------------------------------------------------------
module spi_master_mode_shifter
   import spims_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] tx_byte, [8] miso_level
   input  logic [1:0]            req_tuser,   // [1:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] sck_level, [1] mosi_level, [2] cs_level, [10:3] rx_byte,
   // [11] byte_done, [12] busy_res, [13] rejected
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   cfg_evt_type evt_ff, evt_in;
   logic        wr_en;
   reg_type     reg_idx;

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      evt_in = '0;
      if (wr_en) begin
         case (reg_idx)
            REG_SPI_MODE: begin
               cfg_in.spi_mode = csr_pwdata[1:0];
               evt_in.mode_wr  = 1'b1;
            end
            REG_HALF_DELAY: begin
               cfg_in.half_delay = csr_pwdata[15:0];
            end
            REG_CS_ENABLED: begin
               cfg_in.cs_enabled = csr_pwdata[0];
               evt_in.cs_wr      = 1'b1;
            end
            REG_CS_POL_LOW: begin
               cfg_in.cs_pol_low = csr_pwdata[0];
               evt_in.cs_wr      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_idx)
         REG_SPI_MODE:   csr_prdata = {30'd0, cfg_ff.spi_mode};
         REG_HALF_DELAY: csr_prdata = {16'd0, cfg_ff.half_delay};
         REG_CS_ENABLED: csr_prdata = {31'd0, cfg_ff.cs_enabled};
         REG_CS_POL_LOW: csr_prdata = {31'd0, cfg_ff.cs_pol_low};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{spi_mode: 2'd0, half_delay: 16'd0, cs_enabled: 1'b0,
                     cs_pol_low: 1'b1};
         evt_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         evt_ff <= evt_in;
      end
   end

   spims_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   spims_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   spims_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_evt    (evt_ff),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/sv/spi_master_mode_shifter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_master_mode_shifter_tb
// Self-checking testbench for the SPI master mode shifter. Commands and ticks
// go in on the request stream. A behavioral model of the shifter predicts the
// pin levels, received byte and status flags for every item. Responses are
// compared field by field, in order, against those predictions. Registers are
// written through the APB port while nothing is in flight, and each write is
// read back. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module spi_master_mode_shifter_tb;
   import spims_pkg::*;

   localparam int ITEM_TARGET = 1620;

   // Response fields, packed to line up with rsp_tdata[13:0]
   typedef struct packed {
      logic       rejected;
      logic       busy;
      logic       byte_done;
      logic [7:0] rx_byte;
      logic       cs;
      logic       mosi;
      logic       sck;
   } pin_result_type;

   // Phases of one bit
   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_TRAIL = 2'd1,
      PH_HOLD  = 2'd2
   } bit_phase_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] tx_byte, [8] miso_level
   logic [1:0]            req_tuser;   // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] sck_level, [1] mosi_level, [2] cs_level, [10:3] rx_byte,
   // [11] byte_done, [12] busy_res, [13] rejected
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spi_master_mode_shifter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shifter model state and configuration
   cfg_type       cur_cfg;
   logic [7:0]    sh_tx;
   logic [7:0]    sh_rx;
   logic [2:0]    sh_bit;
   bit_phase_type sh_phase;
   logic [15:0]   sh_ticks;
   logic          sh_active;
   logic          pin_sck;
   logic          pin_mosi;
   logic          pin_cs;

   pin_result_type expected_pins_q[$];
   pin_result_type rsp_got;
   pin_result_type rsp_want;
   int             mismatch_count = 0;
   int             items_sent = 0;
   bit             stall_on = 1'b0;
   int             rsp_hold = 0;

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Drop the shifter back to idle: used at reset and on a mode write
   function automatic void park_shifter();
      sh_active = 1'b0;
      sh_bit    = 3'd0;
      sh_phase  = PH_LEAD;
      sh_ticks  = 16'd0;
      pin_sck   = cur_cfg.spi_mode[1];
      pin_mosi  = 1'b0;
   endfunction

   // Pin actions at the start of each bit
   function automatic void bit_start();
      if (cur_cfg.spi_mode[0])
         pin_sck = ~cur_cfg.spi_mode[1];
      pin_mosi = sh_tx[3'd7 - sh_bit];
      sh_phase = PH_LEAD;
      sh_ticks = 16'd0;
   endfunction

   // Advance the model by one item and return the response it should produce
   function automatic pin_result_type spi_step_predict(op_type op, logic [7:0] txb,
                                                       logic miso);
      pin_result_type r;
      logic [16:0]    limit;
      logic           cpol;
      logic           cpha;
      r     = '0;
      cpol  = cur_cfg.spi_mode[1];
      cpha  = cur_cfg.spi_mode[0];
      limit = (cur_cfg.half_delay == 16'd0) ? 17'd1 : {1'b0, cur_cfg.half_delay};
      if (op != OP_TICK && sh_active) begin
         r.rejected = 1'b1;
      end else begin
         case (op)
            OP_START: begin
               sh_tx     = txb;
               sh_rx     = 8'd0;
               sh_bit    = 3'd0;
               sh_active = 1'b1;
               bit_start();
            end
            OP_SELECT: begin
               if (cur_cfg.cs_enabled)
                  pin_cs = ~cur_cfg.cs_pol_low;
            end
            OP_DESELECT: begin
               if (cur_cfg.cs_enabled)
                  pin_cs = cur_cfg.cs_pol_low;
            end
            default: begin
               if (sh_active) begin
                  if ({1'b0, sh_ticks} + 17'd1 >= limit) begin
                     sh_ticks = 16'd0;
                     case (sh_phase)
                        PH_LEAD: begin
                           pin_sck  = cpha ? cpol : ~cpol;
                           sh_phase = PH_TRAIL;
                        end
                        PH_TRAIL: begin
                           sh_rx = {sh_rx[6:0], miso};
                           if (!cpha)
                              pin_sck = cpol;
                           sh_phase = PH_HOLD;
                        end
                        default: begin
                           if (sh_bit == 3'd7) begin
                              r.byte_done = 1'b1;
                              r.rx_byte   = sh_rx;
                              sh_active   = 1'b0;
                              sh_bit      = 3'd0;
                              sh_phase    = PH_LEAD;
                           end else begin
                              sh_bit = sh_bit + 3'd1;
                              bit_start();
                           end
                        end
                     endcase
                  end else begin
                     sh_ticks = sh_ticks + 16'd1;
                  end
               end
            end
         endcase
      end
      r.sck  = pin_sck;
      r.mosi = pin_mosi;
      r.cs   = pin_cs;
      r.busy = sh_active;
      return r;
   endfunction

   // Send one item, with a random gap in front when idling is on
   task automatic send_cmd(op_type op, logic [7:0] txb, logic miso);
      int gap;
      gap = stall_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, miso, txb};
      do @(posedge clock); while (!req_tready);
      expected_pins_q.push_back(spi_step_predict(op, txb, miso));
      items_sent++;
   endtask

   // Stop sending and let every outstanding response arrive
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pins_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write followed by a read-back
   task automatic csr_write(reg_type r, logic [31:0] v);
      logic [31:0] kept;
      wait_idle();
      case (r)
         REG_SPI_MODE:   kept = v & 32'h3;
         REG_HALF_DELAY: kept = v & 32'hFFFF;
         default:        kept = v & 32'h1;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_SPI_MODE: begin
            cur_cfg.spi_mode = kept[1:0];
            park_shifter();
         end
         REG_HALF_DELAY: cur_cfg.half_delay = kept[15:0];
         REG_CS_ENABLED: begin
            cur_cfg.cs_enabled = kept[0];
            pin_cs = cur_cfg.cs_pol_low;
         end
         default: begin
            cur_cfg.cs_pol_low = kept[0];
            pin_cs = cur_cfg.cs_pol_low;
         end
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr read-back", kept, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Ticks with random MISO until the byte ends or the cut count is hit;
   // noise items (commands while busy) are mixed in at the given percentage
   task automatic run_ticks(int noise_pct, int cut_at);
      int n;
      n = 0;
      while (sh_active && (cut_at == 0 || n < cut_at)) begin
         if ($urandom_range(1, 100) <= noise_pct)
            send_cmd(op_type'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
         else
            send_cmd(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         n++;
      end
   endtask

   task automatic transfer_byte(logic [7:0] b, int noise_pct, int cut_at);
      send_cmd(OP_START, b, 1'($urandom_range(0, 1)));
      run_ticks(noise_pct, cut_at);
   endtask

   // Idle ticks, CS commands with CS off, commands while busy, abort by mode write
   task automatic test_directed();
      send_cmd(OP_TICK, 8'h00, 1'b1);
      send_cmd(OP_SELECT, 8'h00, 1'b0);
      send_cmd(OP_DESELECT, 8'h00, 1'b0);
      send_cmd(OP_START, 8'hFF, 1'b0);
      send_cmd(OP_START, 8'h00, 1'b1);
      send_cmd(OP_SELECT, 8'hFF, 1'b1);
      send_cmd(OP_DESELECT, 8'h55, 1'b0);
      send_cmd(OP_TICK, 8'h00, 1'b1);
      send_cmd(OP_TICK, 8'h00, 1'b1);
      send_cmd(OP_TICK, 8'h00, 1'b0);
      send_cmd(OP_TICK, 8'hFF, 1'b1);
      csr_write(REG_SPI_MODE, 32'd3);
      send_cmd(OP_TICK, 8'h00, 1'b1);
      csr_write(REG_CS_ENABLED, 32'd1);
      send_cmd(OP_SELECT, 8'h00, 1'b0);
      send_cmd(OP_DESELECT, 8'h00, 1'b0);
      csr_write(REG_CS_POL_LOW, 32'd0);
      send_cmd(OP_SELECT, 8'h00, 1'b0);
      send_cmd(OP_DESELECT, 8'h00, 1'b0);
   endtask

   // Full bytes in every mode and both CS polarities
   task automatic test_mode_sweep();
      logic [7:0] patterns[8];
      patterns = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h7F, 8'hFE};
      for (int m = 0; m < 4; m++) begin
         for (int pol = 0; pol < 2; pol++) begin
            stall_on = (pol == 1);
            csr_write(REG_SPI_MODE, m);
            csr_write(REG_CS_ENABLED, 32'd1);
            csr_write(REG_CS_POL_LOW, pol);
            csr_write(REG_HALF_DELAY, m % 3);
            send_cmd(OP_SELECT, 8'h00, 1'b0);
            transfer_byte(patterns[m * 2 + pol], 0, 0);
            send_cmd(OP_DESELECT, 8'h00, 1'b0);
         end
      end
   endtask

   // Register writes while a byte is in progress
   task automatic test_live_config();
      stall_on = 1'b1;
      csr_write(REG_SPI_MODE, 32'd1);
      csr_write(REG_CS_ENABLED, 32'd1);
      csr_write(REG_CS_POL_LOW, 32'd1);
      // long phase cut short: count already past the new length
      csr_write(REG_HALF_DELAY, 32'd65535);
      send_cmd(OP_SELECT, 8'h00, 1'b0);
      transfer_byte(8'hC3, 0, 10);
      csr_write(REG_HALF_DELAY, 32'd3);
      run_ticks(0, 0);
      // CS polarity and enable changed mid-byte
      transfer_byte(8'h3C, 0, 20);
      csr_write(REG_CS_POL_LOW, 32'd0);
      run_ticks(10, 10);
      csr_write(REG_CS_ENABLED, 32'd0);
      run_ticks(10, 0);
      // mode write aborts the byte
      transfer_byte(8'h96, 0, 15);
      csr_write(REG_SPI_MODE, 32'd2);
      send_cmd(OP_TICK, 8'h00, 1'b1);
      transfer_byte(8'h69, 0, 0);
      csr_write(REG_HALF_DELAY, $urandom_range(0, 65535));
      transfer_byte(8'hE7, 0, 5);
      csr_write(REG_SPI_MODE, 32'd0);
      csr_write(REG_HALF_DELAY, 32'd0);
   endtask

   // Random configurations with mostly well-formed transfers plus noise
   task automatic test_random_traffic();
      int dsel;
      int cut;
      while (items_sent < ITEM_TARGET) begin
         stall_on = ($urandom_range(0, 3) != 0);
         csr_write(REG_SPI_MODE, $urandom_range(0, 3));
         dsel = $urandom_range(0, 19);
         if (dsel < 13)
            csr_write(REG_HALF_DELAY, $urandom_range(0, 1));
         else if (dsel < 19)
            csr_write(REG_HALF_DELAY, $urandom_range(2, 3));
         else
            csr_write(REG_HALF_DELAY, $urandom_range(4, 6));
         csr_write(REG_CS_ENABLED, $urandom_range(0, 1));
         csr_write(REG_CS_POL_LOW, $urandom_range(0, 1));
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
               send_cmd(OP_SELECT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : 0;
            transfer_byte(8'($urandom_range(0, 255)), 8, cut);
            repeat ($urandom_range(0, 2))
               send_cmd(op_type'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
               send_cmd(OP_DESELECT, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Response side: random stalls and in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got = pin_result_type'(rsp_tdata[13:0]);
            if (expected_pins_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               rsp_want = expected_pins_q.pop_front();
               check_field("sck_level", 32'(rsp_want.sck), 32'(rsp_got.sck));
               check_field("mosi_level", 32'(rsp_want.mosi), 32'(rsp_got.mosi));
               check_field("cs_level", 32'(rsp_want.cs), 32'(rsp_got.cs));
               check_field("rx_byte", 32'(rsp_want.rx_byte), 32'(rsp_got.rx_byte));
               check_field("byte_done", 32'(rsp_want.byte_done),
                           32'(rsp_got.byte_done));
               check_field("busy_res", 32'(rsp_want.busy), 32'(rsp_got.busy));
               check_field("rejected", 32'(rsp_want.rejected), 32'(rsp_got.rejected));
            end
            rsp_hold = stall_on ? $urandom_range(0, 5) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_TICK;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_cfg     = '{spi_mode: 2'd0, half_delay: 16'd0, cs_enabled: 1'b0,
                      cs_pol_low: 1'b1};
      sh_tx       = 8'd0;
      sh_rx       = 8'd0;
      park_shifter();
      pin_cs      = cur_cfg.cs_pol_low;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_mode_sweep();
      test_live_config();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Timeout
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
